@@ src/uhf_pkg.sv @@
// Shared constants and types for the UDP test header generator.
package uhf_pkg;

    localparam int MaxFrameLenDefault = 9018;

    localparam int LenW  = 14;
    localparam int CfgIw = 3;
    localparam int CfgDw = 48;

    localparam logic [CfgIw-1:0] CFG_SRC_BASE   = 3'd0;
    localparam logic [CfgIw-1:0] CFG_DST_ADDR   = 3'd1;
    localparam logic [CfgIw-1:0] CFG_ADDR_OFS   = 3'd2;
    localparam logic [CfgIw-1:0] CFG_ADDR_CNT   = 3'd3;
    localparam logic [CfgIw-1:0] CFG_VLAN_EN    = 3'd4;
    localparam logic [CfgIw-1:0] CFG_VLAN_CNT   = 3'd5;
    localparam logic [CfgIw-1:0] CFG_MAC_OVR    = 3'd6;
    localparam logic [CfgIw-1:0] CFG_DEST_MAC   = 3'd7;

    localparam logic [15:0] UDP_SRC_PORT = 16'd2012;
    localparam logic [15:0] UDP_DST_PORT = 16'd3000;
    localparam logic [15:0] IP_ID        = 16'd2012;
    localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
    localparam logic [7:0]  IP_TTL       = 8'd64;
    localparam logic [7:0]  V6_HOPS      = 8'hFF;
    localparam logic [15:0] ETH_VLAN     = 16'h8100;
    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [15:0] ETH_IPV6     = 16'h86DD;

    localparam int SumSteps = 9;

    typedef struct packed {
        logic       start;      // capture item, kick modulo units
        logic       step_sum;   // accumulate one checksum term
        logic [3:0] sum_idx;
        logic       load_word;  // load output register
        logic [3:0] word_idx;
    } t_cmd;

    typedef struct packed {
        logic       mod_done;
        logic [3:0] nwords;
    } t_sts;

endpackage

@@ src/uhf_mod.sv @@
// Iterative restoring remainder unit, one dividend bit per cycle.
module uhf_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q, r_rem, r_div;
    logic [32:0] n_t;
    logic [31:0] n_rem;

    always_comb begin
        n_t = {r_rem, r_q[31]};
        if (n_t >= {1'b0, r_div}) begin
            n_rem = 32'(n_t - {1'b0, r_div});
        end else begin
            n_rem = n_t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

@@ src/uhf_dp.sv @@
// Datapath: config registers, modulo units, checksum accumulators, word builder.
module uhf_dp #(
    parameter int MAX_FRAME_LEN = uhf_pkg::MaxFrameLenDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [uhf_pkg::CfgIw-1:0] i_cfg_index,
    input  logic [uhf_pkg::CfgDw-1:0] i_cfg_data,
    input  logic [31:0]             i_packet_index,
    input  logic                    i_use_ipv6,
    input  logic [uhf_pkg::LenW-1:0] i_packet_len,
    input  uhf_pkg::t_cmd           i_cmd,
    output uhf_pkg::t_sts           o_sts,
    output logic [63:0]             o_header_word,
    output logic [3:0]              o_valid_bytes,
    output logic                    o_is_last,
    output logic [uhf_pkg::LenW-1:0] o_zero_fill_len
);
    import uhf_pkg::*;

    localparam logic [LenW-1:0] MaxLen = LenW'(MAX_FRAME_LEN);

    logic [31:0] r_src_base, r_dst_addr, r_addr_ofs, r_addr_cnt;
    logic        r_vlan_en, r_mac_ovr;
    logic [11:0] r_vlan_cnt;
    logic [47:0] r_dest_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= 32'h0A00_0001;
            r_dst_addr <= 32'hC0A8_0001;
            r_addr_ofs <= '0;
            r_addr_cnt <= 32'd1;
            r_vlan_en  <= 1'b0;
            r_vlan_cnt <= 12'd1;
            r_mac_ovr  <= 1'b0;
            r_dest_mac <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_BASE: r_src_base <= i_cfg_data[31:0];
                CFG_DST_ADDR: r_dst_addr <= i_cfg_data[31:0];
                CFG_ADDR_OFS: r_addr_ofs <= i_cfg_data[31:0];
                CFG_ADDR_CNT: r_addr_cnt <= i_cfg_data[31:0];
                CFG_VLAN_EN:  r_vlan_en  <= i_cfg_data[0];
                CFG_VLAN_CNT: r_vlan_cnt <= i_cfg_data[11:0];
                CFG_MAC_OVR:  r_mac_ovr  <= i_cfg_data[0];
                CFG_DEST_MAC: r_dest_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture: clamp length, header geometry
    logic [6:0]      n_hdr;
    logic [LenW-1:0] n_lc, n_len;
    logic [3:0]      n_nwords;

    logic            r_v6;
    logic [6:0]      r_hdr, r_l2;
    logic [LenW-1:0] r_len;
    logic [3:0]      r_nwords, r_lastnv;

    always_comb begin
        n_hdr    = 7'((r_vlan_en ? 18 : 14) + (i_use_ipv6 ? 40 : 20) + 8);
        n_lc     = (i_packet_len > MaxLen) ? MaxLen : i_packet_len;
        n_len    = (n_lc < LenW'(n_hdr)) ? LenW'(n_hdr) : n_lc;
        n_nwords = 4'((n_hdr + 7'd7) >> 3);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_v6     <= i_use_ipv6;
            r_hdr    <= n_hdr;
            r_l2     <= r_vlan_en ? 7'd18 : 7'd14;
            r_len    <= n_len;
            r_nwords <= n_nwords;
            r_lastnv <= 4'(n_hdr - {n_nwords - 4'd1, 3'b000});
        end
    end

    // index modulo address count and VLAN count
    logic [31:0] acnt, vcnt, arem, vrem;
    logic        adone, vdone;

    assign acnt = (r_addr_cnt == '0) ? 32'd1 : r_addr_cnt;
    assign vcnt = (r_vlan_cnt == '0) ? 32'd1 : {20'd0, r_vlan_cnt};

    uhf_mod u_amod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.start),
        .i_dividend(i_packet_index), .i_divisor(acnt),
        .o_done(adone), .o_rem(arem)
    );

    uhf_mod u_vmod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.start),
        .i_dividend(i_packet_index), .i_divisor(vcnt),
        .o_done(vdone), .o_rem(vrem)
    );

    assign o_sts.mod_done = adone & vdone;
    assign o_sts.nwords   = r_nwords;

    logic [31:0] src;
    logic [15:0] vid, udp_len, tot_len;

    assign src     = r_src_base + r_addr_ofs + arem;
    assign vid     = {4'd0, vrem[11:0]} + 16'd1;
    assign udp_len = 16'(r_len - LenW'(r_hdr) + LenW'(8));
    assign tot_len = 16'(r_len - LenW'(r_l2));

    // checksum accumulation, end-around carry
    logic [15:0] r_ipsum, r_udpsum, ip_term, udp_term;
    logic [16:0] ip_add, udp_add;

    always_comb begin
        case (i_cmd.sum_idx)
            4'd0: ip_term = 16'h4500;
            4'd1: ip_term = tot_len;
            4'd2: ip_term = IP_ID;
            4'd3: ip_term = {IP_TTL, IP_PROTO_UDP};
            4'd4: ip_term = src[31:16];
            4'd5: ip_term = src[15:0];
            4'd6: ip_term = r_dst_addr[31:16];
            4'd7: ip_term = r_dst_addr[15:0];
            default: ip_term = '0;
        endcase
        case (i_cmd.sum_idx)
            4'd0: udp_term = {8'd0, IP_PROTO_UDP};
            4'd1: udp_term = udp_len;
            4'd2: udp_term = src[31:16];
            4'd3: udp_term = src[15:0];
            4'd4: udp_term = r_dst_addr[31:16];
            4'd5: udp_term = r_dst_addr[15:0];
            4'd6: udp_term = UDP_SRC_PORT;
            4'd7: udp_term = UDP_DST_PORT;
            4'd8: udp_term = udp_len;
            default: udp_term = '0;
        endcase
        ip_add  = {1'b0, r_ipsum} + {1'b0, ip_term};
        udp_add = {1'b0, r_udpsum} + {1'b0, udp_term};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ipsum  <= '0;
            r_udpsum <= '0;
        end else if (i_cmd.step_sum) begin
            r_ipsum  <= ip_add[15:0] + {15'd0, ip_add[16]};
            r_udpsum <= udp_add[15:0] + {15'd0, udp_add[16]};
        end
    end

    // header assembly
    logic [15:0]  ip_ck, udp_ck, eth_type;
    logic [47:0]  dmac;
    logic [159:0] v4hdr;
    logic [319:0] v6hdr;
    logic [63:0]  udphdr;
    logic [383:0] l34;
    logic [575:0] frame;
    logic [63:0]  words [9];

    always_comb begin
        ip_ck    = ~r_ipsum;
        udp_ck   = (r_udpsum == 16'hFFFF) ? 16'hFFFF : ~r_udpsum;
        eth_type = r_v6 ? ETH_IPV6 : ETH_IPV4;
        dmac     = r_mac_ovr ? r_dest_mac : 48'h0001_0203_0405;
        v4hdr    = {16'h4500, tot_len, IP_ID, 16'h0000, IP_TTL, IP_PROTO_UDP,
                    ip_ck, src, r_dst_addr};
        v6hdr    = {32'h6000_0000, udp_len, IP_PROTO_UDP, V6_HOPS,
                    src, 96'd0, r_dst_addr, 96'd0};
        udphdr   = {UDP_SRC_PORT, UDP_DST_PORT, udp_len, udp_ck};
        l34      = r_v6 ? {v6hdr, udphdr} : {v4hdr, udphdr, 160'd0};
        if (r_vlan_en) begin
            frame = {dmac, 48'h0607_0809_0A0B, ETH_VLAN, vid, eth_type, l34, 48'd0};
        end else begin
            frame = {dmac, 48'h0607_0809_0A0B, eth_type, l34, 80'd0};
        end
        for (int k = 0; k < 9; k++) begin
            words[k] = frame[575 - 64*k -: 64];
        end
    end

    logic w_last;
    assign w_last = (i_cmd.word_idx == r_nwords - 4'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            o_header_word   <= words[i_cmd.word_idx];
            o_valid_bytes   <= w_last ? r_lastnv : 4'd8;
            o_is_last       <= w_last;
            o_zero_fill_len <= w_last ? r_len - LenW'(r_hdr) : '0;
        end
    end
endmodule

@@ src/uhf_ctrl.sv @@
// Controller: accepts an item, sequences modulo, checksum and word output.
module uhf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  uhf_pkg::t_sts i_sts,
    output uhf_pkg::t_cmd o_cmd
);
    import uhf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_SUM  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_ov, n_ov;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_ov          = r_ov & ~i_out_ready;
        o_cmd         = '0;
        o_cmd.sum_idx = r_cnt;
        o_cmd.word_idx = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    n_cnt   = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.step_sum = 1'b1;
                n_cnt          = r_cnt + 4'd1;
                if (r_cnt == 4'(SumSteps - 1)) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.load_word = 1'b1;
                    n_ov            = 1'b1;
                    n_cnt           = r_cnt + 4'd1;
                    if (r_cnt == i_sts.nwords - 4'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
endmodule

@@ src/udp_test_packet_header_forge.sv @@
// Top level: UDP test packet header generator with IPv4/UDP checksums.
//
//  channel   direction  handshake                      payload
//  in        input      i_in_valid / o_in_ready        packet_index, use_ipv6, packet_len
//  out       output     o_out_valid / i_out_ready      header_word, valid_bytes, is_last,
//                                                      zero_fill_len
//  cfg       input      i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// An item passes through the bit-serial modulo units (index mod address count
// and mod VLAN count, run side by side), then 9 checksum accumulation steps,
// then one header word (6, 8 or 9 of them) per cycle while the output is not stalled.
// Reset is synchronous, active low; config returns to its documented defaults.
// A stalled output holds the word register and pauses the word sequence; the
// next item may be accepted while the final word still waits to be taken.
module udp_test_packet_header_forge #(
    parameter int MAX_FRAME_LEN = uhf_pkg::MaxFrameLenDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [uhf_pkg::CfgIw-1:0] i_cfg_index,
    input  logic [uhf_pkg::CfgDw-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [31:0]               i_packet_index,
    input  logic                      i_use_ipv6,
    input  logic [uhf_pkg::LenW-1:0]  i_packet_len,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [63:0]               o_header_word,
    output logic [3:0]                o_valid_bytes,
    output logic                      o_is_last,
    output logic [uhf_pkg::LenW-1:0]  o_zero_fill_len
);
    import uhf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    uhf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    // header construction and checksums
    uhf_dp #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_packet_index(i_packet_index), .i_use_ipv6(i_use_ipv6),
        .i_packet_len(i_packet_len),
        .i_cmd(cmd), .o_sts(sts),
        .o_header_word(o_header_word), .o_valid_bytes(o_valid_bytes),
        .o_is_last(o_is_last), .o_zero_fill_len(o_zero_fill_len)
    );
endmodule

@@ tb/uhf_header_checker.sv @@
// Checker for the UDP header generator: predicts header words per request and compares.
module uhf_header_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [uhf_pkg::CfgIw-1:0] i_cfg_index,
    input  logic [uhf_pkg::CfgDw-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [31:0]               i_packet_index,
    input  logic                      i_use_ipv6,
    input  logic [uhf_pkg::LenW-1:0]  i_packet_len,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [63:0]               i_header_word,
    input  logic [3:0]                i_valid_bytes,
    input  logic                      i_is_last,
    input  logic [uhf_pkg::LenW-1:0]  i_zero_fill_len,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_words_seen
);
    import uhf_pkg::*;

    localparam int MaxLen = MaxFrameLenDefault;

    typedef struct packed {
        logic [63:0]     word;
        logic [3:0]      nbytes;
        logic            last;
        logic [LenW-1:0] fill;
    } t_hdr_word;

    t_hdr_word   hdr_q[$];
    logic [31:0] src_base, dst_ip, ofs, acnt;
    logic        vlan_on, mac_on;
    logic [11:0] vcnt;
    logic [47:0] dmac;

    function automatic logic [31:0] csum_add(logic [31:0] s, logic [15:0] v);
        s = s + 32'(v);
        if (s > 32'hFFFF) s = s - 32'hFFFF;
        return s;
    endfunction

    task automatic forge_headers(logic [31:0] idx, logic v6, logic [LenW-1:0] len_in);
        logic [7:0]  fb[72];
        int          l2, iph, hsz, len, ulen, nw, nv;
        logic [31:0] src, s, dv, ck;
        t_hdr_word   e;
        for (int i = 0; i < 72; i++) fb[i] = (i < 12) ? 8'(i) : 8'h00;
        if (mac_on) for (int i = 0; i < 6; i++) fb[i] = dmac[47-8*i -: 8];
        l2 = 14;
        if (vlan_on) begin
            dv = (vcnt == 0) ? 32'd1 : 32'(vcnt);
            {fb[12], fb[13]} = ETH_VLAN;
            {fb[14], fb[15]} = 16'((idx % dv) + 1);
            l2 = 18;
        end
        iph = v6 ? 40 : 20;
        hsz = l2 + iph + 8;
        len = int'(len_in);
        if (len > MaxLen) len = MaxLen;
        if (len < hsz) len = hsz;
        ulen = len - l2 - iph;
        src = src_base + ofs + (idx % ((acnt == 0) ? 32'd1 : acnt));
        if (v6) begin
            {fb[l2-2], fb[l2-1]} = ETH_IPV6;
            fb[l2] = 8'h60;
            {fb[l2+4], fb[l2+5]} = 16'(ulen);
            fb[l2+6] = IP_PROTO_UDP;
            fb[l2+7] = V6_HOPS;
            {fb[l2+8], fb[l2+9], fb[l2+10], fb[l2+11]} = src;
            {fb[l2+24], fb[l2+25], fb[l2+26], fb[l2+27]} = dst_ip;
        end else begin
            {fb[l2-2], fb[l2-1]} = ETH_IPV4;
            fb[l2] = 8'h45;
            {fb[l2+2], fb[l2+3]} = 16'(len - l2);
            {fb[l2+4], fb[l2+5]} = IP_ID;
            fb[l2+8] = IP_TTL;
            fb[l2+9] = IP_PROTO_UDP;
            {fb[l2+12], fb[l2+13], fb[l2+14], fb[l2+15]} = src;
            {fb[l2+16], fb[l2+17], fb[l2+18], fb[l2+19]} = dst_ip;
            s = 0;
            for (int i = 0; i < 20; i += 2) s = csum_add(s, {fb[l2+i], fb[l2+i+1]});
            {fb[l2+10], fb[l2+11]} = ~s[15:0];
        end
        {fb[l2+iph], fb[l2+iph+1]} = UDP_SRC_PORT;
        {fb[l2+iph+2], fb[l2+iph+3]} = UDP_DST_PORT;
        {fb[l2+iph+4], fb[l2+iph+5]} = 16'(ulen);
        s = 32'(IP_PROTO_UDP) + 32'(ulen);
        if (v6) for (int i = 0; i < 32; i += 2) s = csum_add(s, {fb[l2+8+i], fb[l2+9+i]});
        else for (int i = 0; i < 8; i += 2) s = csum_add(s, {fb[l2+12+i], fb[l2+13+i]});
        for (int i = 0; i < 8; i += 2) s = csum_add(s, {fb[l2+iph+i], fb[l2+iph+i+1]});
        ck = {16'h0, ~s[15:0]};
        if (ck == 0) ck = 32'hFFFF;   // zero checksum goes out as all ones
        {fb[l2+iph+6], fb[l2+iph+7]} = ck[15:0];
        nw = (hsz + 7) / 8;
        for (int w = 0; w < nw; w++) begin
            nv = hsz - w*8;
            if (nv > 8) nv = 8;
            e.word = '0;
            for (int i = 0; i < 8; i++) e.word = {e.word[55:0], (i < nv) ? fb[w*8+i] : 8'h00};
            e.nbytes = 4'(nv);
            e.last   = (w == nw - 1);
            e.fill   = e.last ? LenW'(len - hsz) : '0;
            hdr_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_hdr_word e;
        if (!i_rst_n) begin
            src_base <= 32'd167772161; dst_ip <= 32'd3232235521; ofs <= '0; acnt <= 32'd1;
            vlan_on <= 1'b0; vcnt <= 12'd1; mac_on <= 1'b0; dmac <= '0;
            hdr_q.delete();
            o_errors <= 0;
            o_words_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SRC_BASE: src_base <= i_cfg_data[31:0];
                    CFG_DST_ADDR: dst_ip   <= i_cfg_data[31:0];
                    CFG_ADDR_OFS: ofs      <= i_cfg_data[31:0];
                    CFG_ADDR_CNT: acnt     <= i_cfg_data[31:0];
                    CFG_VLAN_EN:  vlan_on  <= i_cfg_data[0];
                    CFG_VLAN_CNT: vcnt     <= i_cfg_data[11:0];
                    CFG_MAC_OVR:  mac_on   <= i_cfg_data[0];
                    CFG_DEST_MAC: dmac     <= i_cfg_data[47:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                forge_headers(i_packet_index, i_use_ipv6, i_packet_len);
            if (i_out_valid && i_out_ready) begin
                o_words_seen <= o_words_seen + 1;
                if (hdr_q.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got %h",
                             $time, i_header_word);
                    o_errors <= o_errors + 1;
                end else begin
                    e = hdr_q.pop_front();
                    if ({i_header_word, i_valid_bytes, i_is_last, i_zero_fill_len} != e) begin
                        $display("%0t: mismatch: expected word %h bytes %0d last %0d fill %0d,",
                                 $time, e.word, e.nbytes, e.last, e.fill);
                        $display("    got word %h bytes %0d last %0d fill %0d",
                                 i_header_word, i_valid_bytes, i_is_last, i_zero_fill_len);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= hdr_q.size();
        end
    end
endmodule

@@ tb/udp_test_packet_header_forge_tb.sv @@
// Testbench top for the UDP test header generator: stimulus, config phases and verdict.
module udp_test_packet_header_forge_tb;
    import uhf_pkg::*;

    logic              clk, rst_n;
    logic              cfg_we;
    logic [CfgIw-1:0]  cfg_index;
    logic [CfgDw-1:0]  cfg_data;
    logic              in_valid, in_ready;
    logic [31:0]       pkt_index;
    logic              ip_ver;
    logic [LenW-1:0]   pkt_len;
    logic              out_valid, out_ready;
    logic [63:0]       header_word;
    logic [3:0]        valid_bytes;
    logic              is_last;
    logic [LenW-1:0]   zero_fill_len;
    int                errors, pending, words_seen;
    int                idle_cycles, items_sent;
    bit                hung, stall_on;

    // Limit on cycles without any handshake: covers the worst item's work plus
    // long output stalls and input gaps.
    localparam int StallLimit = 5000;

    udp_test_packet_header_forge dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_packet_index(pkt_index), .i_use_ipv6(ip_ver), .i_packet_len(pkt_len),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_header_word(header_word), .o_valid_bytes(valid_bytes),
        .o_is_last(is_last), .o_zero_fill_len(zero_fill_len)
    );

    uhf_header_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_packet_index(pkt_index), .i_use_ipv6(ip_ver), .i_packet_len(pkt_len),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_header_word(header_word), .i_valid_bytes(valid_bytes),
        .i_is_last(is_last), .i_zero_fill_len(zero_fill_len),
        .o_errors(errors), .o_pending(pending), .o_words_seen(words_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // Receiver back-pressure; stall_on switches whole stretches of no stalling.
    initial begin
        int g;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            if (stall_on && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                g = gap_len() + 1;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
        end
    end

    // Watchdog: counts cycles with no handshake on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit && !hung) begin
            hung = 1'b1;
            $display("udp_test_packet_header_forge_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIw-1:0] idx, logic [CfgDw-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one item and hold it until taken. Valid is only dropped when
    // a gap follows, so back-to-back items keep it high.
    task automatic send_item(logic [31:0] idx, logic v6, logic [LenW-1:0] len);
        int g;
        in_valid  <= 1'b1;
        pkt_index <= idx;
        ip_ver    <= v6;
        pkt_len   <= len;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
        g = stall_on ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // Idle the input and wait for the last word; the block is then finishing nothing else.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic logic [LenW-1:0] rand_len();
        case ($urandom_range(0, 5))
            0: return LenW'($urandom_range(0, 90));          // around and below header size
            1: return LenW'($urandom_range(9000, 16383));    // around and above the frame limit
            2: return LenW'($urandom);                       // any 14-bit pattern
            default: return LenW'($urandom_range(60, 1518));
        endcase
    endfunction

    function automatic logic [31:0] rand_index();
        return ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5) : $urandom;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_item(rand_index(), 1'($urandom), rand_len());
    endtask

    initial begin
        hung = 1'b0; stall_on = 1'b1; items_sent = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; pkt_index = '0; ip_ver = 1'b0; pkt_len = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings, both IP versions, length extremes.
        send_item(32'd0, 1'b0, 14'd60);
        send_item(32'd0, 1'b1, 14'd60);
        send_item(32'hFFFF_FFFF, 1'b0, 14'd0);       // short, raised to header size
        send_item(32'hFFFF_FFFF, 1'b1, 14'h3FFF);    // long, cut to the frame limit
        send_item(32'd5, 1'b0, 14'd9018);
        send_item(32'd6, 1'b1, 14'd9019);
        drain();

        // VLAN tag, MAC override, address cycling.
        write_reg(CFG_VLAN_EN, 48'd1);
        write_reg(CFG_VLAN_CNT, 48'd4094);
        write_reg(CFG_MAC_OVR, 48'd1);
        write_reg(CFG_DEST_MAC, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_ADDR_CNT, 48'hFFFF_FFFF);
        write_reg(CFG_ADDR_OFS, 48'hFFFF_FFFF);
        write_reg(CFG_SRC_BASE, 48'hFFFF_FFFF);
        write_reg(CFG_DST_ADDR, 48'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 1'b0, 14'd60);
        send_item(32'hFFFF_FFFF, 1'b1, 14'd0);
        send_item(32'd4093, 1'b0, 14'd1000);
        send_item(32'd4094, 1'b1, 14'd100);
        drain();

        // Zero counts are treated as one.
        write_reg(CFG_ADDR_CNT, 48'd0);
        write_reg(CFG_VLAN_CNT, 48'd0);
        write_reg(CFG_SRC_BASE, 48'd0);
        write_reg(CFG_DST_ADDR, 48'd0);
        write_reg(CFG_ADDR_OFS, 48'd0);
        write_reg(CFG_DEST_MAC, 48'd0);
        send_item(32'd12345, 1'b0, 14'd60);
        send_item(32'd12345, 1'b1, 14'd70);
        drain();

        // Random phases over random settings; the middle one has no idling.
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_SRC_BASE, 48'($urandom));
            write_reg(CFG_DST_ADDR, 48'($urandom));
            write_reg(CFG_ADDR_OFS, 48'($urandom));
            write_reg(CFG_ADDR_CNT, ($urandom_range(0, 1) == 0) ? 48'($urandom_range(0, 9))
                                                             : 48'($urandom));
            write_reg(CFG_VLAN_EN, 48'($urandom_range(0, 1)));
            write_reg(CFG_VLAN_CNT, 48'($urandom_range(0, 4095)));
            write_reg(CFG_MAC_OVR, 48'($urandom_range(0, 1)));
            write_reg(CFG_DEST_MAC, {16'($urandom), 32'($urandom)});
            stall_on = (p != 2);
            random_phase(50);
            drain();
        end

        $display("Sent %0d requests, checked %0d header words across VLAN, MAC, address",
                 items_sent, words_seen);
        $display("and length-clamp settings with random input and output stalls.");
        if (errors == 0) begin
            $display("udp_test_packet_header_forge_tb: clean");
        end else begin
            $display("udp_test_packet_header_forge_tb: errors");
        end
        $finish;
    end
endmodule
